@@ sv/fcce_pkg.sv @@
// ============================================================================
// fcce_pkg
// Shared constants and pipeline stage types of the friction cone evaluator.
// ============================================================================
`default_nettype none

package fcce_pkg;

    localparam int unsigned MU_W = 20;

    localparam logic [MU_W-1:0] MU_RST = 20'd45875;
    localparam logic [31:0] REG_RST = 32'd65536;
    localparam logic [31:0] SHIFT_RST = 32'd0;

    localparam logic [1:0] CFG_MU = 2'd0;
    localparam logic [1:0] CFG_REG = 2'd1;
    localparam logic [1:0] CFG_SHIFT = 2'd2;

    localparam int SQRT_STEPS = 32;
    localparam int FRAC_STEPS = 32;
    localparam int QDIV_STEPS = 33;
    localparam int DDIV_STEPS = 48;
    localparam int DIV_STAGES = 1 + FRAC_STEPS + QDIV_STEPS;

    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;

    // Row and column of the six upper-triangle Hessian outputs.
    localparam int HESS_J [6] = '{0, 0, 0, 1, 1, 2};
    localparam int HESS_K [6] = '{0, 1, 2, 1, 2, 2};

    typedef struct packed {
        logic [8:0][31:0]   rot;
        logic signed [37:0] cone;
        logic               flag;
    } t_side;

    typedef struct packed {
        logic [63:0]        v;
        logic [63:0]        res;
        logic [63:0]        s;
        logic [63:0]        nxx;
        logic [63:0]        nyy;
        logic [63:0]        sxy;
        logic signed [31:0] l0;
        logic signed [31:0] l1;
        logic signed [36:0] cone_pre;
        t_side              side;
    } t_sq;

    typedef struct packed {
        logic [31:0]       t;
        logic [63:0]       s;
        logic              szero;
        logic [2:0][63:0]  fr;
        logic [2:0][32:0]  fq;
        logic [2:0][31:0]  qrem;
        logic [1:0][47:0]  dnum;
        logic [1:0][31:0]  drem;
        logic [1:0]        lneg;
        logic              hneg;
        t_side             side;
    } t_div;

endpackage

`default_nettype wire

@@ sv/friction_cone_constraint_eval.sv @@
// ============================================================================
// friction_cone_constraint_eval
// Smoothed friction cone value, gradient and Hessian for one contact force.
// ============================================================================
// The input channel (i_valid / o_stall) carries a world-frame force and a
// world-to-terrain rotation; the output channel (o_valid / i_stall) carries
// the cone value, the gradient, the upper Hessian triangle and a flag that
// tells whether any value was clipped. One transfer in gives one transfer out.
// The block is a 108-stage pipeline: four front stages, 32 square root
// stages, one stage that fixes the tangential magnitude, 66 stages of
// restoring division (the fractions and the divisions by the magnitude, one
// quotient bit per stage) and five back stages. A new item can be taken in
// every cycle while the receiver does not stall.
// When the receiver stalls while a result is waiting, the whole pipeline
// holds and o_stall is raised; nothing is lost or repeated.
// Synchronous reset empties the pipeline and loads the register defaults.
// Register writes are taken at any time but must only happen while idle.
`default_nettype none

module friction_cone_constraint_eval (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_force_world_x,
    input  wire logic signed [31:0] i_force_world_y,
    input  wire logic signed [31:0] i_force_world_z,
    input  wire logic signed [31:0] i_rot_00,
    input  wire logic signed [31:0] i_rot_01,
    input  wire logic signed [31:0] i_rot_02,
    input  wire logic signed [31:0] i_rot_10,
    input  wire logic signed [31:0] i_rot_11,
    input  wire logic signed [31:0] i_rot_12,
    input  wire logic signed [31:0] i_rot_20,
    input  wire logic signed [31:0] i_rot_21,
    input  wire logic signed [31:0] i_rot_22,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_cone_value,
    output logic signed [31:0]      o_grad_x,
    output logic signed [31:0]      o_grad_y,
    output logic signed [31:0]      o_grad_z,
    output logic signed [31:0]      o_hess_xx,
    output logic signed [31:0]      o_hess_xy,
    output logic signed [31:0]      o_hess_xz,
    output logic signed [31:0]      o_hess_yy,
    output logic signed [31:0]      o_hess_yz,
    output logic signed [31:0]      o_hess_zz,
    output logic                    o_saturated
);

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > fcce_pkg::MAX32) begin
            return 32'sh7fffffff;
        end else if (v < fcce_pkg::MIN32) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic ovf32(input logic signed [63:0] v);
        return (v > fcce_pkg::MAX32) || (v < fcce_pkg::MIN32);
    endfunction

    logic [fcce_pkg::MU_W-1:0] r_mu;
    logic [31:0]               r_reg;
    logic [31:0]               r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu    <= fcce_pkg::MU_RST;
            r_reg   <= fcce_pkg::REG_RST;
            r_shift <= fcce_pkg::SHIFT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fcce_pkg::CFG_MU:    r_mu    <= i_cfg_wdata[fcce_pkg::MU_W-1:0];
                fcce_pkg::CFG_REG:   r_reg   <= i_cfg_wdata;
                fcce_pkg::CFG_SHIFT: r_shift <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_o_vld;

    assign w_en    = !r_o_vld || !i_stall;
    assign o_stall = !w_en;
    assign o_valid = r_o_vld;

    logic [8:0][31:0] w_rot;
    logic [2:0][31:0] w_f;

    assign w_rot = {i_rot_22, i_rot_21, i_rot_20, i_rot_12, i_rot_11, i_rot_10,
                    i_rot_02, i_rot_01, i_rot_00};
    assign w_f   = {i_force_world_z, i_force_world_y, i_force_world_x};

    // Stage 1: products of the rotation with the force.
    logic               r_s1_vld;
    logic signed [63:0] r_s1_p [9];
    logic signed [63:0] n_s1_p [9];
    fcce_pkg::t_side    r_s1_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_s1_p[i*3+j] = $signed(w_rot[i*3+j]) * $signed(w_f[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_valid;
        end
        if (w_en) begin
            r_s1_p         <= n_s1_p;
            r_s1_side.rot  <= w_rot;
            r_s1_side.cone <= '0;
            r_s1_side.flag <= 1'b0;
        end
    end

    // Stage 2: local force.
    logic               r_s2_vld;
    logic signed [31:0] r_s2_l [3];
    logic signed [31:0] n_s2_l [3];
    fcce_pkg::t_side    r_s2_side;
    fcce_pkg::t_side    n_s2_side;

    always_comb begin
        logic signed [63:0] w_sum;
        n_s2_side = r_s1_side;
        for (int i = 0; i < 3; i++) begin
            w_sum = (r_s1_p[i*3] >>> 30) + (r_s1_p[i*3+1] >>> 30)
                  + (r_s1_p[i*3+2] >>> 30);
            n_s2_l[i] = sat32(w_sum);
            if (ovf32(w_sum)) begin
                n_s2_side.flag = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
        if (w_en) begin
            r_s2_l    <= n_s2_l;
            r_s2_side <= n_s2_side;
        end
    end

    // Stage 3: squares and mu times local z.
    logic               r_s3_vld;
    logic [63:0]        r_s3_sxx;
    logic [63:0]        r_s3_syy;
    logic [63:0]        r_s3_sxy;
    logic signed [52:0] r_s3_mulz;
    logic signed [31:0] r_s3_l0;
    logic signed [31:0] r_s3_l1;
    fcce_pkg::t_side    r_s3_side;
    logic [32:0]        w_nx;
    logic [32:0]        w_ny;
    logic [31:0]        w_ux;
    logic [31:0]        w_uy;

    assign w_nx = -{r_s2_l[0][31], r_s2_l[0]};
    assign w_ny = -{r_s2_l[1][31], r_s2_l[1]};
    assign w_ux = r_s2_l[0][31] ? w_nx[31:0] : r_s2_l[0];
    assign w_uy = r_s2_l[1][31] ? w_ny[31:0] : r_s2_l[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s3_vld <= r_s2_vld;
        end
        if (w_en) begin
            r_s3_sxx  <= 64'(w_ux) * 64'(w_ux);
            r_s3_syy  <= 64'(w_uy) * 64'(w_uy);
            r_s3_sxy  <= 64'(w_ux) * 64'(w_uy);
            r_s3_mulz <= $signed({1'b0, r_mu}) * r_s2_l[2];
            r_s3_l0   <= r_s2_l[0];
            r_s3_l1   <= r_s2_l[1];
            r_s3_side <= r_s2_side;
        end
    end

    // Stage 4: radicand and the fraction numerators.
    logic          r_s4_vld;
    fcce_pkg::t_sq r_s4;
    fcce_pkg::t_sq n_s4;
    logic [63:0]   w_regq;

    assign w_regq = {16'd0, r_reg, 16'd0};

    always_comb begin
        n_s4.s        = r_s3_sxx + r_s3_syy + w_regq;
        n_s4.v        = n_s4.s;
        n_s4.res      = '0;
        n_s4.nxx      = r_s3_sxx + w_regq;
        n_s4.nyy      = r_s3_syy + w_regq;
        n_s4.sxy      = r_s3_sxy;
        n_s4.l0       = r_s3_l0;
        n_s4.l1       = r_s3_l1;
        n_s4.cone_pre = 37'(r_s3_mulz >>> 16);
        n_s4.side     = r_s3_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (w_en) begin
            r_s4_vld <= r_s3_vld;
        end
        if (w_en) begin
            r_s4 <= n_s4;
        end
    end

    // Square root, two radicand bits per stage.
    logic          r_sq_vld [fcce_pkg::SQRT_STEPS];
    fcce_pkg::t_sq r_sq     [fcce_pkg::SQRT_STEPS];
    fcce_pkg::t_sq n_sq     [fcce_pkg::SQRT_STEPS];

    for (genvar k = 0; k < fcce_pkg::SQRT_STEPS; k++) begin : g_sq
        localparam logic [63:0] SqBit = 64'd1 << (62 - 2 * k);
        fcce_pkg::t_sq w_in;
        logic          w_in_vld;
        logic [63:0]   w_try;

        if (k == 0) begin : g_first
            assign w_in     = r_s4;
            assign w_in_vld = r_s4_vld;
        end else begin : g_next
            assign w_in     = r_sq[k-1];
            assign w_in_vld = r_sq_vld[k-1];
        end

        assign w_try = w_in.res + SqBit;

        always_comb begin
            n_sq[k] = w_in;
            if (w_in.v >= w_try) begin
                n_sq[k].v   = w_in.v - w_try;
                n_sq[k].res = (w_in.res >> 1) + SqBit;
            end else begin
                n_sq[k].res = w_in.res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_sq_vld[k] <= w_in_vld;
            end
            if (w_en) begin
                r_sq[k] <= n_sq[k];
            end
        end
    end

    // Magnitude fix-up and divider set-up.
    localparam int SqLast = fcce_pkg::SQRT_STEPS - 1;

    logic           r_st_vld;
    fcce_pkg::t_div r_st;
    fcce_pkg::t_div n_st;
    logic [31:0]    w_t;
    logic [32:0]    w_l0n;
    logic [32:0]    w_l1n;
    logic [31:0]    w_ax;
    logic [31:0]    w_ay;

    assign w_t   = (r_sq[SqLast].res == 64'd0) ? 32'd1 : r_sq[SqLast].res[31:0];
    assign w_l0n = -{r_sq[SqLast].l0[31], r_sq[SqLast].l0};
    assign w_l1n = -{r_sq[SqLast].l1[31], r_sq[SqLast].l1};
    assign w_ax  = r_sq[SqLast].l0[31] ? w_l0n[31:0] : r_sq[SqLast].l0;
    assign w_ay  = r_sq[SqLast].l1[31] ? w_l1n[31:0] : r_sq[SqLast].l1;

    always_comb begin
        n_st.t         = w_t;
        n_st.s         = r_sq[SqLast].s;
        n_st.szero     = (r_sq[SqLast].s == 64'd0);
        n_st.fr[0]     = r_sq[SqLast].nyy;
        n_st.fr[1]     = r_sq[SqLast].nxx;
        n_st.fr[2]     = r_sq[SqLast].sxy;
        n_st.fq        = '0;
        n_st.qrem      = '0;
        n_st.dnum[0]   = {w_ax, 16'd0};
        n_st.dnum[1]   = {w_ay, 16'd0};
        n_st.drem      = '0;
        n_st.lneg      = {r_sq[SqLast].l1[31], r_sq[SqLast].l0[31]};
        n_st.hneg      = r_sq[SqLast].l0[31] ^ r_sq[SqLast].l1[31];
        n_st.side      = r_sq[SqLast].side;
        n_st.side.cone = 38'(r_sq[SqLast].cone_pre) - 38'({6'd0, w_t});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld <= 1'b0;
        end else if (w_en) begin
            r_st_vld <= r_sq_vld[SqLast];
        end
        if (w_en) begin
            r_st <= n_st;
        end
    end

    // Restoring dividers: fractions over the radicand, then over the
    // magnitude; the gradient quotients run alongside.
    logic           r_dv_vld [fcce_pkg::DIV_STAGES];
    fcce_pkg::t_div r_dv     [fcce_pkg::DIV_STAGES];
    fcce_pkg::t_div n_dv     [fcce_pkg::DIV_STAGES];

    for (genvar k = 0; k < fcce_pkg::DIV_STAGES; k++) begin : g_dv
        fcce_pkg::t_div w_in;
        logic           w_in_vld;

        if (k == 0) begin : g_first
            assign w_in     = r_st;
            assign w_in_vld = r_st_vld;
        end else begin : g_next
            assign w_in     = r_dv[k-1];
            assign w_in_vld = r_dv_vld[k-1];
        end

        always_comb begin
            logic [64:0] w_r2;
            logic [64:0] w_r2d;
            logic [32:0] w_rq;
            logic [32:0] w_rqd;
            logic [32:0] w_rd;
            logic [32:0] w_rdd;
            n_dv[k] = w_in;
            for (int i = 0; i < 3; i++) begin
                w_r2  = {w_in.fr[i], 1'b0};
                w_r2d = w_r2 - {1'b0, w_in.s};
                w_rq  = {w_in.qrem[i], w_in.fq[i][32]};
                w_rqd = w_rq - {1'b0, w_in.t};
                if (k == 0) begin
                    if (w_in.fr[i] >= w_in.s) begin
                        n_dv[k].fq[i] = 33'd1;
                        n_dv[k].fr[i] = w_in.fr[i] - w_in.s;
                    end else begin
                        n_dv[k].fq[i] = 33'd0;
                    end
                end else if (k <= fcce_pkg::FRAC_STEPS) begin
                    if (w_r2 >= {1'b0, w_in.s}) begin
                        n_dv[k].fr[i] = w_r2d[63:0];
                        n_dv[k].fq[i] = {w_in.fq[i][31:0], 1'b1};
                    end else begin
                        n_dv[k].fr[i] = w_r2[63:0];
                        n_dv[k].fq[i] = {w_in.fq[i][31:0], 1'b0};
                    end
                end else begin
                    if (w_rq >= {1'b0, w_in.t}) begin
                        n_dv[k].qrem[i] = w_rqd[31:0];
                        n_dv[k].fq[i]   = {w_in.fq[i][31:0], 1'b1};
                    end else begin
                        n_dv[k].qrem[i] = w_rq[31:0];
                        n_dv[k].fq[i]   = {w_in.fq[i][31:0], 1'b0};
                    end
                end
            end
            for (int i = 0; i < 2; i++) begin
                w_rd  = {w_in.drem[i], w_in.dnum[i][47]};
                w_rdd = w_rd - {1'b0, w_in.t};
                if (k < fcce_pkg::DDIV_STEPS) begin
                    if (w_rd >= {1'b0, w_in.t}) begin
                        n_dv[k].drem[i] = w_rdd[31:0];
                        n_dv[k].dnum[i] = {w_in.dnum[i][46:0], 1'b1};
                    end else begin
                        n_dv[k].drem[i] = w_rd[31:0];
                        n_dv[k].dnum[i] = {w_in.dnum[i][46:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[k] <= w_in_vld;
            end
            if (w_en) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    localparam int DvLast = fcce_pkg::DIV_STAGES - 1;

    // P1: local Hessian entries and signed gradient coefficients.
    logic               r_p1_vld;
    logic signed [31:0] r_p1_h [3];
    logic signed [31:0] n_p1_h [3];
    logic signed [48:0] r_p1_d [2];
    logic signed [48:0] n_p1_d [2];
    fcce_pkg::t_side    r_p1_side;
    fcce_pkg::t_side    n_p1_side;

    always_comb begin
        logic [32:0]        w_qq [3];
        logic [33:0]        w_neg;
        logic [31:0]        w_mag;
        logic signed [48:0] w_dm;
        n_p1_side = r_dv[DvLast].side;
        for (int i = 0; i < 3; i++) begin
            w_qq[i] = r_dv[DvLast].szero ? 33'd0 : r_dv[DvLast].fq[i];
        end
        for (int i = 0; i < 2; i++) begin
            w_neg = -{1'b0, w_qq[i]};
            if (w_qq[i] > 33'h080000000) begin
                n_p1_h[i] = 32'sh80000000;
                n_p1_side.flag = 1'b1;
            end else begin
                n_p1_h[i] = w_neg[31:0];
            end
        end
        if (w_qq[2] > 33'h07fffffff) begin
            w_mag = 32'h7fffffff;
            n_p1_side.flag = 1'b1;
        end else begin
            w_mag = w_qq[2][31:0];
        end
        n_p1_h[2] = r_dv[DvLast].hneg ? -w_mag : w_mag;
        for (int i = 0; i < 2; i++) begin
            w_dm = {1'b0, r_dv[DvLast].dnum[i]};
            n_p1_d[i] = r_dv[DvLast].lneg[i] ? w_dm : -w_dm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (w_en) begin
            r_p1_vld <= r_dv_vld[DvLast];
        end
        if (w_en) begin
            r_p1_h    <= n_p1_h;
            r_p1_d    <= n_p1_d;
            r_p1_side <= n_p1_side;
        end
    end

    // P2: products for M = H R and for the gradient.
    logic               r_p2_vld;
    logic signed [63:0] r_p2_mp [2][3][2];
    logic signed [63:0] n_p2_mp [2][3][2];
    logic signed [56:0] r_p2_gl [2][3];
    logic signed [56:0] n_p2_gl [2][3];
    logic signed [56:0] r_p2_gh [2][3];
    logic signed [56:0] n_p2_gh [2][3];
    logic signed [52:0] r_p2_gm [3];
    logic signed [52:0] n_p2_gm [3];
    fcce_pkg::t_side    r_p2_side;

    always_comb begin
        logic signed [31:0] w_h0;
        logic signed [31:0] w_h1;
        for (int i = 0; i < 2; i++) begin
            w_h0 = (i == 0) ? r_p1_h[0] : r_p1_h[2];
            w_h1 = (i == 0) ? r_p1_h[2] : r_p1_h[1];
            for (int k = 0; k < 3; k++) begin
                n_p2_mp[i][k][0] = w_h0 * $signed(r_p1_side.rot[k]);
                n_p2_mp[i][k][1] = w_h1 * $signed(r_p1_side.rot[3+k]);
                n_p2_gl[i][k] = $signed({1'b0, r_p1_d[i][23:0]})
                              * $signed(r_p1_side.rot[i*3+k]);
                n_p2_gh[i][k] = $signed(r_p1_d[i][48:24])
                              * $signed(r_p1_side.rot[i*3+k]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            n_p2_gm[k] = $signed({1'b0, r_mu}) * $signed(r_p1_side.rot[6+k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else if (w_en) begin
            r_p2_vld <= r_p1_vld;
        end
        if (w_en) begin
            r_p2_mp   <= n_p2_mp;
            r_p2_gl   <= n_p2_gl;
            r_p2_gh   <= n_p2_gh;
            r_p2_gm   <= n_p2_gm;
            r_p2_side <= r_p1_side;
        end
    end

    // P3: M entries and gradient terms.
    logic               r_p3_vld;
    logic signed [31:0] r_p3_m [2][3];
    logic signed [31:0] n_p3_m [2][3];
    logic signed [50:0] r_p3_gt [3][3];
    logic signed [50:0] n_p3_gt [3][3];
    fcce_pkg::t_side    r_p3_side;
    fcce_pkg::t_side    n_p3_side;

    always_comb begin
        logic signed [63:0] w_ms;
        logic signed [80:0] w_full;
        n_p3_side = r_p2_side;
        for (int i = 0; i < 2; i++) begin
            for (int k = 0; k < 3; k++) begin
                w_ms = (r_p2_mp[i][k][0] >>> 30) + (r_p2_mp[i][k][1] >>> 30);
                n_p3_m[i][k] = sat32(w_ms);
                if (ovf32(w_ms)) begin
                    n_p3_side.flag = 1'b1;
                end
                w_full = $signed({r_p2_gh[i][k], 24'd0}) + 81'(r_p2_gl[i][k]);
                n_p3_gt[i][k] = 51'(w_full >>> 30);
            end
        end
        for (int k = 0; k < 3; k++) begin
            n_p3_gt[2][k] = 51'(r_p2_gm[k] >>> 30);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else if (w_en) begin
            r_p3_vld <= r_p2_vld;
        end
        if (w_en) begin
            r_p3_m    <= n_p3_m;
            r_p3_gt   <= n_p3_gt;
            r_p3_side <= n_p3_side;
        end
    end

    // P4: products for R^T M and gradient sums.
    logic               r_p4_vld;
    logic signed [63:0] r_p4_hp [6][2];
    logic signed [63:0] n_p4_hp [6][2];
    logic signed [52:0] r_p4_g [3];
    logic signed [52:0] n_p4_g [3];
    fcce_pkg::t_side    r_p4_side;

    always_comb begin
        for (int e = 0; e < 6; e++) begin
            n_p4_hp[e][0] = r_p3_m[0][fcce_pkg::HESS_K[e]]
                          * $signed(r_p3_side.rot[fcce_pkg::HESS_J[e]]);
            n_p4_hp[e][1] = r_p3_m[1][fcce_pkg::HESS_K[e]]
                          * $signed(r_p3_side.rot[3+fcce_pkg::HESS_J[e]]);
        end
        for (int k = 0; k < 3; k++) begin
            n_p4_g[k] = 53'(r_p3_gt[0][k]) + 53'(r_p3_gt[1][k]) + 53'(r_p3_gt[2][k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_vld <= 1'b0;
        end else if (w_en) begin
            r_p4_vld <= r_p3_vld;
        end
        if (w_en) begin
            r_p4_hp   <= n_p4_hp;
            r_p4_g    <= n_p4_g;
            r_p4_side <= r_p3_side;
        end
    end

    // Output register with final saturation.
    logic signed [31:0] r_o_val [10];
    logic signed [31:0] n_o_val [10];
    logic               r_o_sat;
    logic               n_o_sat;

    always_comb begin
        logic signed [63:0] w_v [10];
        w_v[0] = 64'(r_p4_side.cone);
        for (int k = 0; k < 3; k++) begin
            w_v[1+k] = 64'(r_p4_g[k]);
        end
        for (int e = 0; e < 6; e++) begin
            w_v[4+e] = (r_p4_hp[e][0] >>> 30) + (r_p4_hp[e][1] >>> 30);
            if (fcce_pkg::HESS_J[e] == fcce_pkg::HESS_K[e]) begin
                w_v[4+e] = w_v[4+e] - $signed({32'd0, r_shift});
            end
        end
        n_o_sat = r_p4_side.flag;
        for (int i = 0; i < 10; i++) begin
            n_o_val[i] = sat32(w_v[i]);
            if (ovf32(w_v[i])) begin
                n_o_sat = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_o_vld <= r_p4_vld;
        end
        if (w_en) begin
            r_o_val <= n_o_val;
            r_o_sat <= n_o_sat;
        end
    end

    assign o_cone_value = r_o_val[0];
    assign o_grad_x     = r_o_val[1];
    assign o_grad_y     = r_o_val[2];
    assign o_grad_z     = r_o_val[3];
    assign o_hess_xx    = r_o_val[4];
    assign o_hess_xy    = r_o_val[5];
    assign o_hess_xz    = r_o_val[6];
    assign o_hess_yy    = r_o_val[7];
    assign o_hess_yz    = r_o_val[8];
    assign o_hess_zz    = r_o_val[9];
    assign o_saturated  = r_o_sat;

`ifndef SYNTHESIS
    logic [64:0] w_chk_t2;
    logic [64:0] w_chk_t1;

    assign w_chk_t2 = {33'd0, r_st.t} * {33'd0, r_st.t};
    assign w_chk_t1 = {33'd0, r_st.t + 32'd1} * {33'd0, r_st.t + 32'd1};

    // The square root is exact: t^2 <= S < (t+1)^2, with t forced to 1 on S = 0.
    a_sqrt_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st_vld && !r_st.szero |-> (w_chk_t2 <= {1'b0, r_st.s}) &&
                                    (w_chk_t1 > {1'b0, r_st.s}))
        else $error("square root stage result is not the floor root");

    // Every division by the magnitude leaves a remainder below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[DvLast] |-> (r_dv[DvLast].drem[0] < r_dv[DvLast].t) &&
                             (r_dv[DvLast].drem[1] < r_dv[DvLast].t) &&
                             (r_dv[DvLast].qrem[0] < r_dv[DvLast].t) &&
                             (r_dv[DvLast].qrem[1] < r_dv[DvLast].t) &&
                             (r_dv[DvLast].qrem[2] < r_dv[DvLast].t))
        else $error("divider remainder not below divisor");

    // A held result keeps the whole pipeline frozen.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_p4_vld) && $stable(r_st_vld) && $stable(r_s1_vld))
        else $error("pipeline moved while output was stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
